@@ design/frlt_pkg.sv @@
package frlt_pkg;

	typedef enum logic [1:0] {
		OP_TEST    = 2'd0,
		OP_LOCK    = 2'd1,
		OP_UNLOCK  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_HELD     = 2'd1,
		ST_NO_ENTRY = 2'd2
	} status_t;

	// one request as it travels from front to back
	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] file_id;
		logic [9:0]  owner;
		logic [31:0] range_begin;
		logic [31:0] range_end;
	} req_t;

	// one result as it leaves the back part
	typedef struct packed {
		logic [1:0] status;
		logic [9:0] conflict_owner;
		logic       wake;
	} res_t;

	// engine phases: conflict scan, modify scan, final write, result
	typedef enum logic [2:0] {
		EN_IDLE,
		EN_TEST,
		EN_MOD,
		EN_WRITE,
		EN_OUT
	} eng_state_t;

endpackage

@@ design/frlt_front.sv @@
module frlt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  frlt_pkg::req_t        in_req,
	output logic                  q_valid,
	input  logic                  q_ready,
	output frlt_pkg::req_t        q_req
);
	import frlt_pkg::*;

	// two-entry queue between intake and the scan engine
	req_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ design/frlt_engine.sv @@
module frlt_engine #(
	parameter int LOCK_ENTRIES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  frlt_pkg::req_t        q_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output frlt_pkg::res_t        out_res
);
	import frlt_pkg::*;

	localparam int IW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] LAST = CW'(LOCK_ENTRIES - 1);

	// payload store: one row per entry, read one row a cycle during a scan
	logic [89:0] store_mem [LOCK_ENTRIES];
	logic [LOCK_ENTRIES-1:0] valid_q;

	eng_state_t st_q, st_d;
	req_t       req_q;
	logic [CW-1:0] idx_q;
	logic [31:0] b_q, e_q;
	logic       split_q, wake_q;
	logic [31:0] sb_q, se_q;
	logic [IW-1:0] slot_q;
	res_t       res_q;
	logic [89:0] row_rd_q;
	logic       rd_ok_q;
	logic [IW-1:0] rd_idx_q;

	// lowest free entry, from the valid bits
	logic [IW-1:0] free_idx;
	logic          free_any;
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = LOCK_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
				free_any = 1'b1;
			end
		end
	end

	// fields of the row read back
	logic [15:0] r_file;
	logic [9:0]  r_own;
	logic [31:0] r_beg, r_end;
	logic        r_val;
	assign {r_file, r_own, r_beg, r_end} = row_rd_q;
	assign r_val = valid_q[rd_idx_q];

	logic mine, conf, touch, ovl;
	assign mine  = rd_ok_q && r_val && r_file == req_q.file_id && r_own == req_q.owner;
	assign conf  = rd_ok_q && r_val && r_file == req_q.file_id && r_own != req_q.owner
		&& req_q.range_end > r_beg && req_q.range_begin < r_end;
	assign touch = !(e_q < r_beg || b_q > r_end);
	assign ovl   = !(req_q.range_end <= r_beg || req_q.range_begin >= r_end);

	logic scan_done;
	assign scan_done = rd_ok_q && ({1'b0, rd_idx_q} == LAST);

	// conflict scan over, hit found, or skipped for unlock and release
	logic test_end;
	assign test_end = scan_done || conf || (!rd_ok_q && idx_q > LAST);

	always_comb begin
		st_d = st_q;
		case (st_q)
			EN_IDLE:  if (q_valid) st_d = EN_TEST;
			EN_TEST:  if (test_end) st_d = EN_MOD;
			EN_MOD:   if (scan_done || res_q.status != ST_DONE
					|| req_q.operation == OP_TEST) st_d = EN_WRITE;
			EN_WRITE: st_d = EN_OUT;
			EN_OUT:   if (out_ready) st_d = EN_IDLE;
			default:  st_d = EN_IDLE;
		endcase
	end

	assign q_ready   = (st_q == EN_IDLE);
	assign out_valid = (st_q == EN_OUT);
	assign out_res   = res_q;

	// row reads: issue idx_q, data in row_rd_q in the next cycle
	logic issue;
	assign issue = (st_q == EN_TEST || st_q == EN_MOD) && idx_q <= LAST;

	logic        wr_en;
	logic [IW-1:0] wr_idx;
	logic [89:0] wr_row;
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = rd_idx_q;
		wr_row = row_rd_q;
		if (st_q == EN_MOD && mine && req_q.operation == OP_UNLOCK && ovl
				&& req_q.range_begin <= r_beg && req_q.range_end < r_end) begin
			wr_en  = 1'b1;
			wr_row = {r_file, r_own, req_q.range_end, r_end};
		end else if (st_q == EN_MOD && mine && req_q.operation == OP_UNLOCK && ovl
				&& req_q.range_begin > r_beg) begin
			wr_en  = 1'b1;
			wr_row = {r_file, r_own, r_beg, req_q.range_begin};
		end else if (st_q == EN_WRITE && res_q.status == ST_DONE
				&& (req_q.operation == OP_LOCK
				|| (req_q.operation == OP_UNLOCK && split_q))) begin
			wr_en  = 1'b1;
			wr_idx = slot_q;
			wr_row = (req_q.operation == OP_LOCK)
				? {req_q.file_id, req_q.owner, b_q, e_q}
				: {req_q.file_id, req_q.owner, sb_q, se_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) store_mem[wr_idx] <= wr_row;
		if (issue) row_rd_q <= store_mem[idx_q[IW-1:0]];
		if (st_q == EN_IDLE && q_valid) req_q <= q_req;
		rd_idx_q <= idx_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= EN_IDLE;
			valid_q <= '0;
			idx_q   <= '0;
			rd_ok_q <= 1'b0;
			res_q   <= '0;
			b_q     <= '0;
			e_q     <= '0;
			sb_q    <= '0;
			se_q    <= '0;
			split_q <= 1'b0;
			wake_q  <= 1'b0;
			slot_q  <= '0;
		end else begin
			st_q    <= st_d;
			rd_ok_q <= issue && !(st_q == EN_TEST && test_end);
			if (st_q == EN_IDLE)
				idx_q <= (q_req.operation == OP_TEST || q_req.operation == OP_LOCK)
					? '0 : LAST + CW'(1);
			else if (st_q == EN_TEST && test_end)
				idx_q <= '0;
			else if (issue)
				idx_q <= idx_q + CW'(1);
			if (wr_en && st_q == EN_WRITE) valid_q[wr_idx] <= 1'b1;
			case (st_q)
				EN_IDLE: begin
					res_q   <= '0;
					split_q <= 1'b0;
					wake_q  <= 1'b0;
					b_q     <= q_req.range_begin;
					e_q     <= q_req.range_end;
				end
				EN_TEST: begin
					if (conf) begin
						res_q.status         <= ST_HELD;
						res_q.conflict_owner <= r_own;
					end
					if (test_end) begin
						slot_q  <= free_idx;
						if (!conf && !free_any && (req_q.operation == OP_LOCK
								|| req_q.operation == OP_UNLOCK))
							res_q.status <= ST_NO_ENTRY;
					end
				end
				EN_MOD: begin
					if (mine) begin
						case (req_q.operation)
							OP_LOCK: if (touch) begin
								if (r_beg < b_q) b_q <= r_beg;
								if (r_end > e_q) e_q <= r_end;
								valid_q[rd_idx_q] <= 1'b0;
								wake_q <= 1'b1;
							end
							OP_UNLOCK: if (ovl) begin
								wake_q <= 1'b1;
								if (req_q.range_begin <= r_beg) begin
									if (req_q.range_end >= r_end)
										valid_q[rd_idx_q] <= 1'b0;
								end else if (req_q.range_end < r_end && !split_q) begin
									split_q <= 1'b1;
									sb_q    <= req_q.range_end;
									se_q    <= r_end;
								end
							end
							OP_RELEASE: begin
								valid_q[rd_idx_q] <= 1'b0;
								wake_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				EN_WRITE: res_q.wake <= wake_q;
				default: ;
			endcase
		end
	end
endmodule

@@ design/file_region_lock_table.sv @@
// file region lock table
// holds a pool of byte-range locks, each tagged with file, owner and a
// half-open range [range_begin, range_end)
// input channel: in_valid / in_ready with operation, file_id, owner,
// range_begin, range_end; one transfer per request
// output channel: out_valid / out_ready with status, conflict_owner, wake;
// exactly one result transfer per request, in request order
// a two-deep queue takes requests while the scan engine is busy
// a lock runs one scan of conflict checking plus one modify scan, each
// reading one pool row a cycle from the entry store; test, unlock and
// release take one scan, a test ends early on a conflict, and a lock
// skips the modify scan when it finds a conflict or no free entry
// the engine takes a request only when idle; scans use the single read port
// reset clears the valid bits of every entry at once, no clearing pass
// when the receiver stalls the result is held and the engine waits, the
// front keeps taking requests until its queue is full
module file_region_lock_table #(
	parameter int LOCK_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] file_id,
	input  logic [9:0]  owner,
	input  logic [31:0] range_begin,
	input  logic [31:0] range_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [9:0]  conflict_owner,
	output logic        wake
);
	import frlt_pkg::*;

	req_t in_req, q_req;
	res_t res;
	logic q_valid, q_ready;

	// pack the request fields
	assign in_req = '{operation: operation, file_id: file_id, owner: owner,
		range_begin: range_begin, range_end: range_end};

	frlt_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	// scan engine over the entry pool
	frlt_engine #(.LOCK_ENTRIES(LOCK_ENTRIES)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_res(res)
	);

	assign status         = res.status;
	assign conflict_owner = res.conflict_owner;
	assign wake           = res.wake;
endmodule

@@ tb/frlt_checker.sv @@
`timescale 1ns / 1ps

module frlt_checker #(
	parameter int LOCK_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] file_id,
	input  logic [9:0]  owner,
	input  logic [31:0] range_begin,
	input  logic [31:0] range_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [9:0]  conflict_owner,
	input  logic        wake,
	output int          fail_count,
	output int          pending
);
	import frlt_pkg::*;

	// shadow copy of the lock pool
	logic        pool_valid [LOCK_ENTRIES];
	logic [15:0] pool_file  [LOCK_ENTRIES];
	logic [9:0]  pool_owner [LOCK_ENTRIES];
	logic [31:0] pool_begin [LOCK_ENTRIES];
	logic [31:0] pool_end   [LOCK_ENTRIES];

	res_t expected_results [$];

	assign pending = expected_results.size();

	function automatic int lowest_free();
		for (int i = 0; i < LOCK_ENTRIES; i++)
			if (!pool_valid[i])
				return i;
		return -1;
	endfunction

	function automatic res_t apply_request(op_t op, logic [15:0] f, logic [9:0] o,
			logic [31:0] b, logic [31:0] e);
		res_t r;
		int slot;
		logic split;
		logic [31:0] sb, se, old_end;
		r = '0;
		split = 1'b0;
		sb = '0;
		se = '0;
		if (op == OP_TEST || op == OP_LOCK) begin
			for (int i = 0; i < LOCK_ENTRIES; i++) begin
				if (pool_valid[i] && pool_file[i] == f && pool_owner[i] != o &&
						e > pool_begin[i] && b < pool_end[i]) begin
					r.status = ST_HELD;
					r.conflict_owner = pool_owner[i];
					break;
				end
			end
		end
		if (op == OP_LOCK && r.status == ST_DONE) begin
			slot = lowest_free();
			if (slot < 0) begin
				r.status = ST_NO_ENTRY;
			end else begin
				for (int i = 0; i < LOCK_ENTRIES; i++) begin
					if (!(pool_valid[i] && pool_file[i] == f && pool_owner[i] == o))
						continue;
					if (e < pool_begin[i] || b > pool_end[i])
						continue;
					if (pool_begin[i] < b)
						b = pool_begin[i];
					if (pool_end[i] > e)
						e = pool_end[i];
					pool_valid[i] = 1'b0;
					r.wake = 1'b1;
				end
				pool_valid[slot] = 1'b1;
				pool_file[slot]  = f;
				pool_owner[slot] = o;
				pool_begin[slot] = b;
				pool_end[slot]   = e;
			end
		end else if (op == OP_UNLOCK) begin
			slot = lowest_free();
			if (slot < 0) begin
				r.status = ST_NO_ENTRY;
			end else begin
				for (int i = 0; i < LOCK_ENTRIES; i++) begin
					if (!(pool_valid[i] && pool_file[i] == f && pool_owner[i] == o))
						continue;
					if (e <= pool_begin[i] || b >= pool_end[i])
						continue;
					r.wake = 1'b1;
					if (b <= pool_begin[i]) begin
						if (e >= pool_end[i])
							pool_valid[i] = 1'b0;
						else
							pool_begin[i] = e;
					end else begin
						old_end = pool_end[i];
						pool_end[i] = b;
						if (e < old_end && !split) begin
							split = 1'b1;
							sb = e;
							se = old_end;
						end
					end
				end
				// upper piece goes in after the scan
				if (split) begin
					pool_valid[slot] = 1'b1;
					pool_file[slot]  = f;
					pool_owner[slot] = o;
					pool_begin[slot] = sb;
					pool_end[slot]   = se;
				end
			end
		end else if (op == OP_RELEASE) begin
			for (int i = 0; i < LOCK_ENTRIES; i++) begin
				if (pool_valid[i] && pool_file[i] == f && pool_owner[i] == o) begin
					pool_valid[i] = 1'b0;
					r.wake = 1'b1;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < LOCK_ENTRIES; i++)
				pool_valid[i] = 1'b0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_request(op_t'(operation), file_id,
					owner, range_begin, range_end));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (status !== exp_r.status) begin
						$error("status expected %0d actual %0d", exp_r.status, status);
						fail_count++;
					end
					if (conflict_owner !== exp_r.conflict_owner) begin
						$error("conflict_owner expected %0d actual %0d",
							exp_r.conflict_owner, conflict_owner);
						fail_count++;
					end
					if (wake !== exp_r.wake) begin
						$error("wake expected %0d actual %0d", exp_r.wake, wake);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

@@ tb/tb_file_region_lock_table.sv @@
`timescale 1ns / 1ps

module tb_file_region_lock_table;
	import frlt_pkg::*;

	localparam int LOCK_ENTRIES = 64;
	localparam int RANDOM_ITEMS = 1500;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [15:0] file_id;
	logic [9:0]  owner;
	logic [31:0] range_begin;
	logic [31:0] range_end;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [9:0]  conflict_owner;
	logic        wake;
	int          fail_count;
	int          pending;

	file_region_lock_table #(.LOCK_ENTRIES(LOCK_ENTRIES)) uut (.*);

	frlt_checker #(.LOCK_ENTRIES(LOCK_ENTRIES)) checker_i (.*);

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stall before taking each result
	initial begin
		int hold;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ready && out_valid) begin
				hold = $urandom_range(0, 4);
				if (hold != 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (hold > 0)
					hold--;
				if (hold == 0)
					out_ready <= 1'b1;
			end
		end
	end

	// one request transfer: random gap if may_idle, then hold valid until accepted
	task automatic send_request(op_t op, logic [15:0] f, logic [9:0] o,
			logic [31:0] b, logic [31:0] e, bit may_idle);
		int gap;
		gap = may_idle ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		file_id     <= f;
		owner       <= o;
		range_begin <= b;
		range_end   <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// draw a small range in a narrow window so that locks overlap and touch
	task automatic send_random(bit may_idle);
		int pick;
		op_t op;
		logic [15:0] f;
		logic [9:0]  o;
		logic [31:0] b, e, base;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			op = OP_LOCK;
		else if (pick < 60)
			op = OP_UNLOCK;
		else if (pick < 85)
			op = OP_TEST;
		else
			op = OP_RELEASE;
		f = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
		o = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3));
		// mostly low offsets, sometimes near the top of the address space
		base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FF00 : 32'h0;
		b = base + 32'($urandom_range(0, 200));
		e = b + 32'($urandom_range(0, 40));
		if ($urandom_range(0, 19) == 0)
			e = b - 32'($urandom_range(1, 10));
		if ($urandom_range(0, 29) == 0) begin
			b = $urandom;
			e = $urandom;
		end
		send_request(op, f, o, b, e, may_idle);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		operation   = OP_TEST;
		file_id     = '0;
		owner       = '0;
		range_begin = '0;
		range_end   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: field extremes and the named corner cases
		send_request(OP_TEST, 16'h0000, 10'd0, 32'h0, 32'hFFFF_FFFF, 1'b0);
		send_request(OP_LOCK, 16'hFFFF, 10'd1023, 32'h0, 32'hFFFF_FFFF, 1'b0);
		// empty range inside a held range still conflicts
		send_request(OP_TEST, 16'hFFFF, 10'd5, 32'd100, 32'd100, 1'b0);
		send_request(OP_LOCK, 16'hFFFF, 10'd5, 32'd10, 32'd20, 1'b0);
		send_request(OP_RELEASE, 16'hFFFF, 10'd1023, 32'h0, 32'h0, 1'b0);
		// touching ranges merge
		send_request(OP_LOCK, 16'd1, 10'd2, 32'd10, 32'd20, 1'b0);
		send_request(OP_LOCK, 16'd1, 10'd2, 32'd20, 32'd30, 1'b0);
		send_request(OP_LOCK, 16'd1, 10'd2, 32'd40, 32'd50, 1'b0);
		send_request(OP_LOCK, 16'd1, 10'd2, 32'd5, 32'd45, 1'b0);
		// unlock: split, trim low, trim high, no match
		send_request(OP_UNLOCK, 16'd1, 10'd2, 32'd20, 32'd25, 1'b0);
		send_request(OP_UNLOCK, 16'd1, 10'd2, 32'd0, 32'd8, 1'b0);
		send_request(OP_UNLOCK, 16'd1, 10'd2, 32'd48, 32'd60, 1'b0);
		send_request(OP_UNLOCK, 16'd1, 10'd2, 32'd100, 32'd200, 1'b0);
		send_request(OP_TEST, 16'd1, 10'd3, 32'd22, 32'd23, 1'b0);
		// reversed range stored as given
		send_request(OP_LOCK, 16'd7, 10'd9, 32'd50, 32'd40, 1'b0);
		send_request(OP_TEST, 16'd7, 10'd8, 32'd45, 32'd46, 1'b0);
		send_request(OP_RELEASE, 16'd7, 10'd9, 32'd0, 32'd0, 1'b0);
		send_request(OP_RELEASE, 16'd1, 10'd2, 32'd0, 32'd0, 1'b0);
		send_request(OP_RELEASE, 16'd1, 10'd2, 32'd0, 32'd0, 1'b0);
		// fill the pool, then lock and unlock find no free entry
		for (int i = 0; i < LOCK_ENTRIES + 1; i++)
			send_request(OP_LOCK, 16'd3, 10'd4, 32'(i * 10), 32'(i * 10 + 5), 1'b1);
		send_request(OP_UNLOCK, 16'd3, 10'd4, 32'd0, 32'd2, 1'b0);
		send_request(OP_TEST, 16'd3, 10'd6, 32'd641, 32'd642, 1'b0);
		send_request(OP_RELEASE, 16'd3, 10'd4, 32'd0, 32'd0, 1'b0);

		// random part, first stretch without idling on the send side
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			send_random(n > 200);
			// occasional clean-up so the pool rarely stays full
			if ($urandom_range(0, 59) == 0)
				for (int f = 0; f < 3; f++)
					for (int o = 0; o < 4; o++)
						send_request(OP_RELEASE, 16'(f), 10'(o), 32'h0, 32'h0, 1'b0);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * LOCK_ENTRIES + 20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_file_region_lock_table passed");
		else
			$display("tb_file_region_lock_table failed");
		$finish;
	end

	// watchdog
	initial begin
		#80ms;
		$display("tb_file_region_lock_table failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/frlt_pkg.sv
design/frlt_front.sv
design/frlt_engine.sv
design/file_region_lock_table.sv
tb/frlt_checker.sv
tb/tb_file_region_lock_table.sv
